// File: sv/chacha_pkg.sv
// ============================================================================
// chacha_pkg
// Shared types, constants and round functions of the ChaCha20 stream XOR.
// ============================================================================
package chacha_pkg;

    localparam int WORDS   = 16;
    localparam int ROUNDS  = 20;
    localparam int ROUND_W = $clog2(ROUNDS);
    localparam int ADDR_W  = 6;

    typedef logic [31:0] word_t;

    // "expand 32-byte k" as big-endian words
    localparam word_t SIGMA [4] = '{32'h6578_7061, 32'h6e64_2033,
                                    32'h322d_6279, 32'h7465_206b};

    // register index, taken from paddr[5:3]
    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_NONCE = 3'd4;

    typedef struct packed {
        logic [63:0] key0;
        logic [63:0] key1;
        logic [63:0] key2;
        logic [63:0] key3;
        logic [63:0] nonce;
    } key_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;   // take the input request
        logic load;      // load working state from the block input
        logic round;     // run one round on the working state
        logic diag;      // diagonal round when set, column round otherwise
        logic finish;    // add block input, bump counter
        logic emit;      // write the result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic need_block;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    function automatic word_t rotl(word_t v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic quad_t quarter(quad_t q_in);
        quad_t q;
        q   = q_in;
        q.a = q.a + q.b;
        q.d = rotl(q.d ^ q.a, 16);
        q.c = q.c + q.d;
        q.b = rotl(q.b ^ q.c, 12);
        q.a = q.a + q.b;
        q.d = rotl(q.d ^ q.a, 8);
        q.c = q.c + q.d;
        q.b = rotl(q.b ^ q.c, 7);
        return q;
    endfunction

endpackage

// File: sv/chacha_ctrl.sv
// ============================================================================
// chacha_ctrl
// Sequencer: takes a request, runs the block rounds when a new keystream
// block is due, then hands the result to the output register.
// ============================================================================
module chacha_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  chacha_pkg::dp_status_t status,
    output chacha_pkg::dp_cmd_t    cmd
);
    import chacha_pkg::*;

    state_t               state_reg, state_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    logic                 last_round;

    assign last_round = (round_reg == ROUND_W'(ROUNDS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.need_block ? ST_LOAD : ST_EMIT;
                end
            end
            ST_LOAD:
            begin
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                round_next = round_reg + 1'b1;
                if (last_round)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                cmd.diag  = round_reg[0];
            end
            ST_FINAL:
            begin
                cmd.finish = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: sv/chacha_datapath.sv
// ============================================================================
// chacha_datapath
// Working state with four quarter-round units, block counter, word position
// and the output register.
// ============================================================================
module chacha_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  chacha_pkg::dp_cmd_t    cmd,
    output chacha_pkg::dp_status_t status,
    input  chacha_pkg::key_cfg_t   cfg,
    input  logic [31:0]            in_word,
    input  logic [2:0]             in_nbytes,
    input  logic                   in_last,
    input  logic                   in_restart,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [31:0]            out_word,
    output logic [2:0]             out_nbytes,
    output logic                   out_last
);
    import chacha_pkg::*;

    // working state, holds the keystream once a block is finished
    word_t        w_reg [WORDS];
    word_t        w_next [WORDS];
    word_t        init [WORDS];
    word_t        round_w [WORDS];

    logic [63:0]  counter_reg, counter_next;
    logic [3:0]   pos_reg, pos_next;
    logic         need_reg, need_next;
    logic         out_valid_reg, out_valid_next;

    logic [31:0]  hold_word_reg;
    logic [2:0]   hold_nbytes_reg;
    logic         hold_last_reg;

    logic [31:0]  out_word_reg;
    logic [2:0]   out_nbytes_reg;
    logic         out_last_reg;

    logic [31:0]  mask;
    logic [31:0]  result;

    assign status.need_block = need_reg | in_restart;
    assign status.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        init[0]  = SIGMA[0];
        init[1]  = SIGMA[1];
        init[2]  = SIGMA[2];
        init[3]  = SIGMA[3];
        init[4]  = cfg.key0[63:32];
        init[5]  = cfg.key0[31:0];
        init[6]  = cfg.key1[63:32];
        init[7]  = cfg.key1[31:0];
        init[8]  = cfg.key2[63:32];
        init[9]  = cfg.key2[31:0];
        init[10] = cfg.key3[63:32];
        init[11] = cfg.key3[31:0];
        init[12] = counter_reg[31:0];
        init[13] = counter_reg[63:32];
        init[14] = cfg.nonce[63:32];
        init[15] = cfg.nonce[31:0];
    end

    // one column or diagonal round: lane i works on a=i and rows b, c, d
    // shifted by 0 (column) or 1, 2, 3 (diagonal)
    always_comb
    begin
        logic [1:0] ln;
        logic [3:0] ib, ic, id;
        quad_t      q;
        round_w = w_reg;
        for (int i = 0; i < 4; i++)
        begin
            ln  = 2'(i);
            ib  = {2'b01, ln + {1'b0, cmd.diag}};
            ic  = {2'b10, ln + {cmd.diag, 1'b0}};
            id  = {2'b11, ln + {cmd.diag, cmd.diag}};
            q.a = w_reg[{2'b00, ln}];
            q.b = w_reg[ib];
            q.c = w_reg[ic];
            q.d = w_reg[id];
            q   = quarter(q);
            round_w[{2'b00, ln}] = q.a;
            round_w[ib]          = q.b;
            round_w[ic]          = q.c;
            round_w[id]          = q.d;
        end
    end

    always_comb
    begin
        w_next = w_reg;
        if (cmd.load)
        begin
            w_next = init;
        end
        else if (cmd.round)
        begin
            w_next = round_w;
        end
        else if (cmd.finish)
        begin
            for (int i = 0; i < WORDS; i++)
            begin
                w_next[i] = w_reg[i] + init[i];
            end
        end
    end

    always_comb
    begin
        case (hold_nbytes_reg)
            3'd1:    mask = 32'hFF00_0000;
            3'd2:    mask = 32'hFFFF_0000;
            3'd3:    mask = 32'hFFFF_FF00;
            default: mask = 32'hFFFF_FFFF;
        endcase
        result = (hold_word_reg ^ w_reg[pos_reg]) & mask;
    end

    always_comb
    begin
        counter_next   = counter_reg;
        pos_next       = pos_reg;
        need_next      = need_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.capture && in_restart)
        begin
            counter_next = '0;
            pos_next     = '0;
            need_next    = 1'b1;
        end
        if (cmd.finish)
        begin
            counter_next = counter_reg + 64'd1;
            pos_next     = '0;
            need_next    = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            // drop the rest of the block at message end or after word 15
            if (hold_last_reg || pos_reg == 4'hF)
            begin
                pos_next  = '0;
                need_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            pos_reg       <= '0;
            need_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            counter_reg   <= counter_next;
            pos_reg       <= pos_next;
            need_reg      <= need_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        if (cmd.capture)
        begin
            hold_word_reg   <= in_word;
            hold_nbytes_reg <= in_nbytes;
            hold_last_reg   <= in_last;
        end
        if (cmd.emit)
        begin
            out_word_reg   <= result;
            out_nbytes_reg <= hold_nbytes_reg;
            out_last_reg   <= hold_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_word   = out_word_reg;
    assign out_nbytes = out_nbytes_reg;
    assign out_last   = out_last_reg;

endmodule

// File: sv/chacha20_stream_xor.sv
// ============================================================================
// chacha20_stream_xor
// ChaCha20 keystream generator XORed onto a stream of 32-bit message words.
// ============================================================================
//
//  channel   dir   signals                          content
//  -------   ---   -------------------------------  ---------------------------
//  s_*       in    s_tvalid s_tready s_tdata        message word and byte count
//                  s_tlast s_tuser                  message end, restart
//  m_*       out   m_tvalid m_tready m_tdata        XORed word and byte count
//                  m_tlast                          message end
//  apb       in    psel penable pwrite paddr        key and nonce registers
//                  pwdata prdata pready
//
//  A word that uses an existing keystream block goes through capture and
//  emit. A word that needs a new block goes through capture, load, 20 rounds
//  on four shared quarter-round units, final add and emit.
//  One request is worked on at a time; the output register lets the next
//  request enter while a result waits on m_tready.
//  Reset clears the block counter, marks a new block as needed and empties
//  the output register; the keystream words are not cleared.
// ============================================================================
module chacha20_stream_xor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,   // data_word[31:0], valid_bytes[34:32]
    input  logic                          s_tlast,
    input  logic                          s_tuser,   // restart
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // out_word[31:0], out_valid_bytes[34:32]
    output logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [chacha_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);
    import chacha_pkg::*;

    key_cfg_t    cfg_reg;
    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [2:0]  reg_idx;
    logic        cfg_write;
    logic [31:0] out_word;
    logic [2:0]  out_nbytes;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[5:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_KEY0:  cfg_reg.key0  <= pwdata;
                REG_KEY1:  cfg_reg.key1  <= pwdata;
                REG_KEY2:  cfg_reg.key2  <= pwdata;
                REG_KEY3:  cfg_reg.key3  <= pwdata;
                REG_NONCE: cfg_reg.nonce <= pwdata;
                default:   cfg_reg       <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KEY0:  prdata = cfg_reg.key0;
            REG_KEY1:  prdata = cfg_reg.key1;
            REG_KEY2:  prdata = cfg_reg.key2;
            REG_KEY3:  prdata = cfg_reg.key3;
            REG_NONCE: prdata = cfg_reg.nonce;
            default:   prdata = '0;
        endcase
    end

    chacha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    chacha_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg        (cfg_reg),
        .in_word    (s_tdata[31:0]),
        .in_nbytes  (s_tdata[34:32]),
        .in_last    (s_tlast),
        .in_restart (s_tuser),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_word   (out_word),
        .out_nbytes (out_nbytes),
        .out_last   (m_tlast)
    );

    assign m_tdata = {5'b0, out_nbytes, out_word};

    // one request in flight: no second capture right after a capture
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request accepted while one is in flight");

    // a restart always forces a fresh block for its word
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> status.need_block)
        else $error("restart did not request a new block");

    // never overwrite a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while stalled");

endmodule

// File: tb/tb_chacha20_stream_xor.sv
// ============================================================================
// tb_chacha20_stream_xor
// Self-checking bench for the ChaCha20 stream XOR block. A short table of
// corner-case words runs first under the reset key, then random messages run
// under several key and nonce settings. An in-bench ChaCha20 model predicts
// each XORed word, and a scoreboard matches the output stream against it.
// ============================================================================
module tb_chacha20_stream_xor;
    import chacha_pkg::*;

    localparam logic [127:0] EXPAND_K   = "expand 32-byte k";
    localparam logic [2:0]   REG_UNUSED = 3'd5;
    localparam logic [2:0]   REG_LIST [5] = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3,
                                              REG_NONCE};

    typedef struct {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
    } cipher_out_t;

    typedef struct {
        logic [31:0] data;
        logic [2:0]  nb;
        logic        last;
        logic        restart;
        logic [2:0]  exp_nb;
        logic        exp_last;
    } step_row_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [39:0]          m_tdata;
    logic                 m_tlast;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_W-1:0]    paddr    = '0;
    logic [63:0]          pwdata   = '0;
    logic [63:0]          prdata;
    logic                 pready;

    // predictor state
    logic [63:0] cfg_regs [5] = '{default: '0};
    logic [63:0] blk_ctr  = '0;
    logic [31:0] ks_word [16];
    logic [31:0] mix [16];
    logic [3:0]  ks_pos   = '0;
    logic        ks_stale = 1'b1;

    cipher_out_t pending_cipher [$];
    int unsigned mismatch_count = 0;
    int unsigned burst_left     = 0;
    int unsigned stall_mode     = 0;
    int unsigned mode_left      = 0;

    step_row_t smoke_rows [22] = '{
        '{32'h0000_0000, 3'd4, 1'b0, 1'b0, 3'd4, 1'b0},
        '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, 3'd4, 1'b0},
        '{32'h0000_0000, 3'd1, 1'b0, 1'b0, 3'd1, 1'b0},   // partial word mid message
        '{32'hFFFF_FFFF, 3'd2, 1'b0, 1'b0, 3'd2, 1'b0},
        '{32'hA5A5_A5A5, 3'd3, 1'b0, 1'b0, 3'd3, 1'b0},
        '{32'h1234_5678, 3'd0, 1'b0, 1'b0, 3'd0, 1'b0},   // zero count acts as full
        '{32'h8000_0001, 3'd5, 1'b0, 1'b0, 3'd5, 1'b0},
        '{32'h7FFF_FFFE, 3'd6, 1'b0, 1'b0, 3'd6, 1'b0},
        '{32'h5555_5555, 3'd7, 1'b0, 1'b0, 3'd7, 1'b0},
        '{32'hAAAA_AAAA, 3'd4, 1'b0, 1'b0, 3'd4, 1'b0},
        '{32'h0000_0001, 3'd4, 1'b0, 1'b0, 3'd4, 1'b0},
        '{32'h8000_0000, 3'd4, 1'b0, 1'b0, 3'd4, 1'b0},
        '{32'hDEAD_BEEF, 3'd4, 1'b0, 1'b0, 3'd4, 1'b0},
        '{32'h0F0F_0F0F, 3'd4, 1'b0, 1'b0, 3'd4, 1'b0},
        '{32'hF0F0_F0F0, 3'd4, 1'b0, 1'b0, 3'd4, 1'b0},
        '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, 3'd4, 1'b0},   // last word of the block
        '{32'h0000_0000, 3'd2, 1'b1, 1'b0, 3'd2, 1'b1},   // second block, partial end
        '{32'h0000_0000, 3'd4, 1'b0, 1'b1, 3'd4, 1'b0},   // restart at message start
        '{32'h0000_0000, 3'd4, 1'b0, 1'b0, 3'd4, 1'b0},
        '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b1, 3'd4, 1'b0},   // restart mid message
        '{32'h1357_9BDF, 3'd4, 1'b1, 1'b0, 3'd4, 1'b1},
        '{32'hFFFF_FFFF, 3'd1, 1'b1, 1'b1, 3'd1, 1'b1}
    };

    chacha20_stream_xor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] rol32(logic [31:0] v, int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void mix_quarter(int a, int b, int c, int d);
        mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 16);
        mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 12);
        mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 8);
        mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 7);
    endfunction

    // Build the next 16 keystream words from key, counter and nonce.
    function automatic void refill_keystream();
        logic [31:0] init_w [16];
        for (int i = 0; i < 4; i++)
            init_w[i] = EXPAND_K[127 - 32 * i -: 32];
        for (int i = 0; i < 4; i++)
        begin
            init_w[4 + 2 * i] = cfg_regs[REG_LIST[i]][63:32];
            init_w[5 + 2 * i] = cfg_regs[REG_LIST[i]][31:0];
        end
        init_w[12] = blk_ctr[31:0];
        init_w[13] = blk_ctr[63:32];
        init_w[14] = cfg_regs[REG_NONCE][63:32];
        init_w[15] = cfg_regs[REG_NONCE][31:0];
        mix = init_w;
        for (int r = 0; r < 10; r++)
        begin
            mix_quarter(0, 4, 8, 12);
            mix_quarter(1, 5, 9, 13);
            mix_quarter(2, 6, 10, 14);
            mix_quarter(3, 7, 11, 15);
            mix_quarter(0, 5, 10, 15);
            mix_quarter(1, 6, 11, 12);
            mix_quarter(2, 7, 8, 13);
            mix_quarter(3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++)
            ks_word[i] = mix[i] + init_w[i];
        blk_ctr = blk_ctr + 64'd1;
    endfunction

    function automatic cipher_out_t chacha_xor_word(logic [31:0] data, logic [2:0] nb,
                                                    logic last, logic restart);
        cipher_out_t r;
        logic [31:0] keep;
        if (restart)
        begin
            blk_ctr  = '0;
            ks_pos   = '0;
            ks_stale = 1'b1;
        end
        if (ks_stale)
        begin
            refill_keystream();
            ks_pos   = '0;
            ks_stale = 1'b0;
        end
        case (nb)
            3'd1:    keep = 32'hFF00_0000;
            3'd2:    keep = 32'hFFFF_0000;
            3'd3:    keep = 32'hFFFF_FF00;
            default: keep = 32'hFFFF_FFFF;
        endcase
        r.word   = (data ^ ks_word[ks_pos]) & keep;
        r.nbytes = nb;
        r.last   = last;
        // drop the rest of the block at message end or after word 15
        if (last || ks_pos == 4'hF)
        begin
            ks_pos   = '0;
            ks_stale = 1'b1;
        end
        else
            ks_pos = ks_pos + 4'd1;
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR at %0t: %s got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic apb_write(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx <= REG_NONCE)
            cfg_regs[idx] = val;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(logic [2:0] idx, output logic [63:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        val = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_keys(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                             logic [63:0] k3, logic [63:0] nv);
        logic [63:0] vals [5];
        logic [63:0] got;
        vals = '{k0, k1, k2, k3, nv};
        foreach (REG_LIST[i])
            apb_write(REG_LIST[i], vals[i]);
        foreach (REG_LIST[i])
        begin
            apb_read(REG_LIST[i], got);
            if (got !== vals[i])
                report("register readback", got, vals[i]);
        end
    endtask

    // Idle the request side between bursts of random length.
    task automatic pace();
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_word(logic [31:0] data, logic [2:0] nb, logic last,
                             logic restart, output cipher_out_t exp);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, nb, data};
        s_tlast  <= last;
        s_tuser  <= restart;
        do @(posedge clk); while (!s_tready);
        exp = chacha_xor_word(data, nb, last, restart);
    endtask

    // Hold until every result is back, then let the block settle.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_cipher.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic run_messages(int unsigned n_words);
        int unsigned sent;
        int unsigned len;
        logic [2:0]  nb;
        logic        last;
        logic        restart;
        cipher_out_t exp;
        sent = 0;
        while (sent < n_words)
        begin
            case ($urandom_range(0, 9))
                0:       len = 16;
                1:       len = $urandom_range(17, 48);
                2:       len = 32;
                default: len = $urandom_range(1, 15);
            endcase
            for (int unsigned w = 0; w < len; w++)
            begin
                last    = (w == len - 1);
                restart = (w == 0) ? ($urandom_range(0, 3) == 0)
                                   : ($urandom_range(0, 59) == 0);
                nb = 3'd4;
                if (last)
                    nb = 3'($urandom_range(1, 4));
                if ($urandom_range(0, 24) == 0)
                    nb = 3'($urandom_range(0, 7));
                pace();
                send_word($urandom, nb, last, restart, exp);
                pending_cipher.push_back(exp);
                sent++;
            end
        end
    endtask

    // Output side stalls in modes: always ready, coin flip, sparse, blocked.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = (stall_mode == 3) ? $urandom_range(5, 40) : $urandom_range(8, 120);
        end
        mode_left--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        cipher_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_cipher.size() == 0)
                report("result with nothing pending", m_tdata, '0);
            else
            begin
                want = pending_cipher.pop_front();
                if (m_tdata[31:0] !== want.word)
                    report("out_word", m_tdata[31:0], want.word);
                if (m_tdata[34:32] !== want.nbytes)
                    report("out_valid_bytes", m_tdata[34:32], want.nbytes);
                if (m_tlast !== want.last)
                    report("out_message_end", m_tlast, want.last);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        cipher_out_t exp;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // corner words under the all-zero reset key
        foreach (smoke_rows[i])
        begin
            pace();
            send_word(smoke_rows[i].data, smoke_rows[i].nb, smoke_rows[i].last,
                      smoke_rows[i].restart, exp);
            exp.nbytes = smoke_rows[i].exp_nb;
            exp.last   = smoke_rows[i].exp_last;
            pending_cipher.push_back(exp);
        end
        drain();

        load_keys('1, '1, '1, '1, '1);
        apb_write(REG_UNUSED, {$urandom, $urandom});
        run_messages(280);
        drain();

        load_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, 64'hFFFF_FFFF_0000_0000);
        run_messages(280);
        drain();

        load_keys('0, '0, '0, '0, 64'h0000_0000_FFFF_FFFF);
        run_messages(280);
        drain();

        load_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
        run_messages(280);
        drain();

        load_keys(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                  64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE,
                  64'h8000_0000_0000_0001);
        run_messages(280);
        drain();

        load_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
        run_messages(280);
        drain();

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
